FILE: sv/length_prefixed_frame_parser_top_macros.svh
// assertion helpers used by the parser top level
`ifndef LENGTH_PREFIXED_FRAME_PARSER_TOP_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPFP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LPFP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/lpfp_pkg.sv
`timescale 1ns / 1ps

package lpfp_pkg;

   // frame layout
   localparam int unsigned HDR_FIXED = 5;
   localparam int unsigned LEN_BYTES = 4;
   localparam logic [15:0] MAX_BODY_RESET = 16'h4000;

   // result kinds
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // one result transaction
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  frame_type;
      logic [31:0] sess_id;
      logic [15:0] pay_len;
      logic [7:0]  payload_byte;
      logic        last;
   } rsp_type;

endpackage

FILE: sv/lpfp_req_if.sv
`timescale 1ns / 1ps

interface lpfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   logic       restart;

   modport source (output valid, output data, output restart, input ready);
   modport sink (input valid, input data, input restart, output ready);
endinterface

FILE: sv/lpfp_rsp_if.sv
`timescale 1ns / 1ps

interface lpfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  frame_type;
   logic [31:0] sess_id;
   logic [15:0] pay_len;
   logic [7:0]  payload_byte;
   logic        last;

   modport source (output valid, output kind, output frame_type, output sess_id,
                   output pay_len, output payload_byte, output last, input ready);
   modport sink (input valid, input kind, input frame_type, input sess_id,
                 input pay_len, input payload_byte, input last, output ready);
endinterface

FILE: sv/lpfp_parser.sv
`timescale 1ns / 1ps

module lpfp_parser
   import lpfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  data,
   input  logic        restart,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output logic        res_valid,
   output rsp_type     res
);

   localparam logic [1:0] PH_LEN     = 2'd0;
   localparam logic [1:0] PH_HDR     = 2'd1;
   localparam logic [1:0] PH_PAY     = 2'd2;
   localparam logic [1:0] PH_DISCARD = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [23:0] len_ff, len_in;
   logic [15:0] plen_ff, plen_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] session_ff, session_in;
   logic [15:0] max_body_ff;

   logic [1:0]  ph;
   logic [15:0] cnt;
   logic [15:0] cnt_inc;
   logic [31:0] body;
   logic [31:0] session_sh;
   logic        bad_len;

   // restart clears the parser before the byte is parsed
   assign ph         = restart ? PH_LEN : phase_ff;
   assign cnt        = restart ? 16'd0 : count_ff;
   assign cnt_inc    = cnt + 16'd1;
   assign body       = {(restart ? 24'd0 : len_ff), data};
   assign session_sh = {session_ff[23:0], data};
   assign bad_len    = (body < 32'(HDR_FIXED)) || (body[31:16] != 16'd0)
                       || (body[15:0] > max_body_ff);

   // next state and result for one byte
   always_comb begin
      phase_in   = ph;
      count_in   = cnt_inc;
      len_in     = restart ? 24'd0 : len_ff;
      plen_in    = plen_ff;
      type_in    = restart ? 8'd0 : type_ff;
      session_in = restart ? 32'd0 : session_ff;
      res_valid  = 1'b0;
      res        = '0;
      unique case (ph)
         PH_LEN: begin
            if (cnt == 16'(LEN_BYTES - 1)) begin
               count_in = 16'd0;
               len_in   = 24'd0;
               if (bad_len) begin
                  phase_in  = PH_DISCARD;
                  res_valid = 1'b1;
                  res.kind  = KIND_ERROR;
                  res.last  = 1'b1;
               end else begin
                  phase_in = PH_HDR;
                  plen_in  = body[15:0] - 16'(HDR_FIXED);
               end
            end else begin
               len_in = body[23:0];
            end
         end
         PH_HDR: begin
            if (cnt == 16'd0) begin
               type_in = data;
            end else begin
               session_in = session_sh;
            end
            if (cnt == 16'(HDR_FIXED - 1)) begin
               count_in        = 16'd0;
               res_valid       = 1'b1;
               res.kind        = KIND_HEADER;
               res.frame_type  = type_ff;
               res.sess_id     = session_sh;
               res.pay_len     = plen_ff;
               res.last        = (plen_ff == 16'd0);
               phase_in        = (plen_ff == 16'd0) ? PH_LEN : PH_PAY;
            end
         end
         PH_PAY: begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.frame_type   = type_ff;
            res.sess_id      = session_ff;
            res.pay_len      = plen_ff;
            res.payload_byte = data;
            res.last         = (cnt_inc >= plen_ff);
            if (cnt_inc >= plen_ff) begin
               phase_in = PH_LEN;
               count_in = 16'd0;
            end
         end
         PH_DISCARD: begin
            count_in = cnt;
         end
      endcase
      if (!accept) begin
         res_valid = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEN;
         count_ff    <= 16'd0;
         len_ff      <= 24'd0;
         max_body_ff <= MAX_BODY_RESET;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
            len_ff   <= len_in;
         end
         if (csr_wr_en) begin
            max_body_ff <= csr_wr_data;
         end
      end
   end

   // held header fields
   always_ff @(posedge clock) begin
      if (accept) begin
         plen_ff    <= plen_in;
         type_ff    <= type_in;
         session_ff <= session_in;
      end
   end

endmodule

FILE: sv/lpfp_rsp_buf.sv
`timescale 1ns / 1ps

module lpfp_rsp_buf
   import lpfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    up_ready,
   output logic    out_valid,
   output rsp_type out_data,
   input  logic    out_ready
);

   logic    main_valid_ff;
   logic    skid_valid_ff;
   rsp_type main_ff;
   rsp_type skid_ff;
   logic    pop;

   assign pop       = main_valid_ff && out_ready;
   assign up_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // valid flags of the two entries
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         priority if (pop && skid_valid_ff) begin
            skid_valid_ff <= 1'b0;
         end else if (pop) begin
            main_valid_ff <= push;
         end else if (push && main_valid_ff) begin
            skid_valid_ff <= 1'b1;
         end else if (push) begin
            main_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= main_valid_ff;
         end
      end
   end

   // entry data
   always_ff @(posedge clock) begin
      priority if (pop && skid_valid_ff) begin
         main_ff <= skid_ff;
      end else if (push && (pop || !main_valid_ff)) begin
         main_ff <= push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end else begin
         main_ff <= main_ff;
      end
   end

endmodule

FILE: sv/length_prefixed_frame_parser_top.sv
// a result is registered in the result buffer as the byte that causes it is taken
// one byte per cycle while req_chan.ready is high, set by the parser state update
// req_chan.ready stays high while the two-entry result buffer has a free entry
// reset (synchronous, active high): parser back to the length phase,
// max_body back to 16384, result buffer empty
`timescale 1ns / 1ps
`include "length_prefixed_frame_parser_top_macros.svh"

module length_prefixed_frame_parser_top
   import lpfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lpfp_req_if.sink    req_chan,
   lpfp_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic    accept;
   logic    buf_ready;
   logic    res_valid;
   rsp_type res;
   rsp_type out_data;

   assign req_chan.ready = buf_ready;
   assign accept         = req_chan.valid && buf_ready;

   // parser state and result logic
   lpfp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data        (req_chan.data),
      .restart     (req_chan.restart),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .res_valid   (res_valid),
      .res         (res)
   );

   // result register with skid entry
   lpfp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .up_ready  (buf_ready),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .out_ready (rsp_chan.ready)
   );

   // unpack result transaction
   assign rsp_chan.kind         = out_data.kind;
   assign rsp_chan.frame_type   = out_data.frame_type;
   assign rsp_chan.sess_id      = out_data.sess_id;
   assign rsp_chan.pay_len      = out_data.pay_len;
   assign rsp_chan.payload_byte = out_data.payload_byte;
   assign rsp_chan.last         = out_data.last;

   // checks
   `LPFP_ASSERT_IMP(a_full_has_output, clock, reset, !req_chan.ready, rsp_chan.valid, "input stalled with no result pending")
   `LPFP_ASSERT_IMP(a_error_last, clock, reset, rsp_chan.valid && (rsp_chan.kind == KIND_ERROR), rsp_chan.last && (rsp_chan.pay_len == 16'd0), "error result malformed")
   `LPFP_ASSERT_IMP(a_empty_frame_last, clock, reset, rsp_chan.valid && (rsp_chan.kind == KIND_HEADER) && (rsp_chan.pay_len == 16'd0), rsp_chan.last, "empty frame header not last")
   `LPFP_ASSERT_NXT(a_stall_hold_full, clock, reset, rsp_chan.valid && !rsp_chan.ready && !req_chan.ready, !req_chan.ready, "buffer lost an entry while stalled")

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top
   import lpfp_pkg::*;
();

   // parser phases tracked alongside the block
   typedef enum logic [1:0] {AWAIT_LEN, IN_HDR, IN_PAY, DROPPING} parse_phase_type;

   // one row of the directed script
   typedef struct packed {
      logic [7:0] data;
      logic       restart;
      logic       fixed;
      rsp_type    want;
   } script_row_type;

   localparam int QUIET_LIMIT = 500;
   localparam int PHASES      = 9;

   localparam rsp_type NO_RSP    = '0;
   localparam rsp_type ERR_RSP   = '{KIND_ERROR, 8'h00, 32'h0, 16'h0, 8'h00, 1'b1};
   localparam rsp_type EMPTY_HDR = '{KIND_HEADER, 8'hFF, 32'hFFFF_FFFF, 16'd0, 8'h00, 1'b1};
   localparam rsp_type ONE_HDR   = '{KIND_HEADER, 8'h5A, 32'h1234_5678, 16'd1, 8'h00, 1'b0};
   localparam rsp_type ONE_PAY   = '{KIND_PAYLOAD, 8'h5A, 32'h1234_5678, 16'd1, 8'h80, 1'b1};

   // directed stream: empty frame, one-byte frame, restart mid-length,
   // length just above the reset limit, length below the fixed header
   localparam script_row_type SCRIPT [0:28] = '{
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h05, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, 1'b1, EMPTY_HDR},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h06, 1'b0, 1'b0, NO_RSP},
      '{8'h5A, 1'b0, 1'b0, NO_RSP},
      '{8'h12, 1'b0, 1'b0, NO_RSP},
      '{8'h34, 1'b0, 1'b0, NO_RSP},
      '{8'h56, 1'b0, 1'b0, NO_RSP},
      '{8'h78, 1'b0, 1'b1, ONE_HDR},
      '{8'h80, 1'b0, 1'b1, ONE_PAY},
      '{8'h7F, 1'b0, 1'b0, NO_RSP},
      '{8'h7F, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h40, 1'b0, 1'b0, NO_RSP},
      '{8'h01, 1'b0, 1'b1, ERR_RSP},
      '{8'h00, 1'b1, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h00, 1'b0, 1'b0, NO_RSP},
      '{8'h04, 1'b0, 1'b1, ERR_RSP}
   };

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   lpfp_req_if req_if ();
   lpfp_rsp_if rsp_if ();

   length_prefixed_frame_parser_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // tracked parser state and limit
   parse_phase_type trk_phase;
   logic [15:0]     trk_count;
   logic [31:0]     trk_body;
   logic [7:0]      trk_type;
   logic [31:0]     trk_session;
   logic [15:0]     trk_max_body;

   rsp_type results_due[$];
   int      mismatch_count = 0;
   int      parsed_items = 0;
   int      quiet_cycles = 0;
   bit      no_idle = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void clear_tracker();
      trk_phase   = AWAIT_LEN;
      trk_count   = '0;
      trk_body    = '0;
      trk_type    = '0;
      trk_session = '0;
   endfunction

   // advance the tracked parser by one byte, return 1 when a result is due
   function automatic bit parse_byte(input logic [7:0] d, input logic rs, output rsp_type r);
      logic [15:0] plen;
      bit          emit;
      r = '0;
      emit = 1'b0;
      if (rs)
         clear_tracker();
      case (trk_phase)
         AWAIT_LEN: begin
            trk_body = {trk_body[23:0], d};
            trk_count++;
            if (trk_count == LEN_BYTES) begin
               trk_count = '0;
               if (trk_body < HDR_FIXED || trk_body > trk_max_body) begin
                  trk_phase = DROPPING;
                  r.kind = KIND_ERROR;
                  r.last = 1'b1;
                  emit = 1'b1;
               end else begin
                  trk_phase = IN_HDR;
               end
            end
         end
         IN_HDR: begin
            if (trk_count == 0)
               trk_type = d;
            else
               trk_session = {trk_session[23:0], d};
            trk_count++;
            if (trk_count == HDR_FIXED) begin
               trk_count = '0;
               plen = 16'(trk_body - HDR_FIXED);
               r = '{KIND_HEADER, trk_type, trk_session, plen, 8'h00, plen == 0};
               emit = 1'b1;
               if (plen == 0) begin
                  trk_phase = AWAIT_LEN;
                  trk_body = '0;
               end else begin
                  trk_phase = IN_PAY;
               end
            end
         end
         IN_PAY: begin
            plen = 16'(trk_body - HDR_FIXED);
            trk_count++;
            r = '{KIND_PAYLOAD, trk_type, trk_session, plen, d, trk_count >= plen};
            emit = 1'b1;
            if (r.last) begin
               trk_phase = AWAIT_LEN;
               trk_count = '0;
               trk_body = '0;
            end
         end
         default: ;
      endcase
      return emit;
   endfunction

   // send one byte transaction and queue what it should produce
   task automatic feed(input logic [7:0] d, input logic rs, input logic fixed,
                       input rsp_type want);
      int      gap;
      rsp_type pred;
      bit      hit;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.data    <= d;
      req_if.restart <= rs;
      do @(posedge clock); while (!req_if.ready);
      if (rs || trk_phase != DROPPING)
         parsed_items++;
      hit = parse_byte(d, rs, pred);
      if (fixed)
         results_due.push_back(want);
      else if (hit)
         results_due.push_back(pred);
   endtask

   // let the block go quiet before touching the limit register
   task automatic drain();
      req_if.valid <= 1'b0;
      while (results_due.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_max_body(input logic [15:0] v);
      csr_wr_data <= v;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      trk_max_body = v;
   endtask

   // one random frame, sometimes cut short, sometimes just line noise
   task automatic run_frame();
      logic [31:0] body;
      logic [31:0] sid;
      logic [7:0]  ftype;
      logic [7:0]  b;
      int          total;
      int          plen;
      int          lim;
      bit          fresh;
      bit          good;
      no_idle = ($urandom_range(0, 3) == 0);
      fresh = (trk_phase != AWAIT_LEN) || (trk_count != 0) || ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 11) == 0) begin
         repeat ($urandom_range(1, 6))
            feed(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, NO_RSP);
         return;
      end
      lim = (trk_max_body < 40) ? int'(trk_max_body) : 40;
      case ($urandom_range(0, 19))
         0: body = 32'(trk_max_body);
         1: body = 32'(trk_max_body) + 1;
         2: body = $urandom_range(0, 4);
         3: body = $urandom;
         4: body = HDR_FIXED;
         default: body = (lim < 5) ? $urandom_range(0, 10) : $urandom_range(5, lim);
      endcase
      ftype = 8'($urandom);
      sid   = $urandom;
      good  = (body >= HDR_FIXED) && (body <= trk_max_body);
      if (good) begin
         plen  = int'(body) - HDR_FIXED;
         total = plen + 9;
         // long payloads are always cut off within the first 40 bytes of the frame
         if (plen > 200 || $urandom_range(0, 7) == 0)
            total = $urandom_range(1, (total - 1 < 40) ? total - 1 : 40);
      end else begin
         total = 4 + $urandom_range(0, 3);
      end
      for (int k = 0; k < total; k++) begin
         if (k < 4)
            b = body[8*(3-k) +: 8];
         else if (k == 4)
            b = ftype;
         else if (k < 9)
            b = sid[8*(8-k) +: 8];
         else
            b = 8'($urandom);
         feed(b, (k == 0) && fresh, 1'b0, NO_RSP);
      end
   endtask

   // result side with random back-pressure
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.kind, rsp_if.frame_type, rsp_if.sess_id, rsp_if.pay_len,
                 rsp_if.payload_byte, rsp_if.last};
         if (results_due.size() == 0) begin
            $error("unexpected result: kind 0x%0h", got.kind);
            mismatch_count++;
         end else begin
            want = results_due.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("frame_type", want.frame_type, got.frame_type);
            check_field("sess_id", want.sess_id, got.sess_id);
            check_field("pay_len", want.pay_len, got.pay_len);
            check_field("payload_byte", want.payload_byte, got.payload_byte);
            check_field("last", want.last, got.last);
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // reset, directed script, then random phases over several limits
   initial begin
      logic [15:0] setting;
      int          quota;
      req_if.valid   <= 1'b0;
      req_if.data    <= '0;
      req_if.restart <= 1'b0;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      reset          <= 1'b1;
      trk_max_body = MAX_BODY_RESET;
      clear_tracker();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(SCRIPT); i++)
         feed(SCRIPT[i].data, SCRIPT[i].restart, SCRIPT[i].fixed, SCRIPT[i].want);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: setting = MAX_BODY_RESET;
            1: setting = 16'hFFFF;
            2: setting = 16'(HDR_FIXED);
            3: setting = 16'd0;
            4: setting = 16'd40;
            5: setting = 16'd4;
            6: setting = MAX_BODY_RESET;
            7: setting = 16'($urandom_range(5, 60));
            default: setting = 16'($urandom_range(0, 65535));
         endcase
         if (ph != 0) begin
            drain();
            write_max_body(setting);
         end
         quota = parsed_items + ((setting < HDR_FIXED) ? 40 : 110);
         while (parsed_items < quota)
            run_frame();
      end

      drain();
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/lpfp_pkg.sv
sv/lpfp_req_if.sv
sv/lpfp_rsp_if.sv
sv/lpfp_parser.sv
sv/lpfp_rsp_buf.sv
sv/length_prefixed_frame_parser_top.sv
tb/tb_top.sv
